FILE: hdl/rnn_token_step_and_argmax_core_defines.svh
// assertion macros for the rnn token step and argmax core
// used by the port checker, no other dependencies
`ifndef RNN_TOKEN_STEP_AND_ARGMAX_CORE_DEFINES_SVH
`define RNN_TOKEN_STEP_AND_ARGMAX_CORE_DEFINES_SVH

// plain property check under reset
`define RTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rts assertion failed");

// stalled valid holds with a stable signal
`define RTS_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("rts hold assertion failed");

`endif

FILE: hdl/rts_pkg.sv
// shared types, constants and the tanh approximation of the rnn core
// no dependencies
`default_nettype none

package rts_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned TOKEN_W  = 8;
  localparam int unsigned PRED_W   = 8;
  localparam int unsigned CONF_W   = 4;
  localparam int unsigned MARGIN_W = 31;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned HID_W    = 16;

  localparam logic [CONF_W-1:0] CONF_MAX = 4'd8;
  localparam int unsigned DRAIN_CYCLES = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_IN  = 3'd0,
    KIND_LOAD_REC = 3'd1,
    KIND_LOAD_OUT = 3'd2,
    KIND_STEP     = 3'd3,
    KIND_PREDICT  = 3'd4,
    KIND_SAVE     = 3'd5,
    KIND_RESTORE  = 3'd6,
    KIND_CLEAR    = 3'd7
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_SCALE   = 8'd0,
    CFG_ROUND_SHIFT   = 8'd1,
    CFG_PRODUCT_SHIFT = 8'd2,
    CFG_CONF_DIVISOR  = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic pred;
  } op_t;

  typedef struct packed {
    logic rot;
    logic nx_shift;
    logic commit;
    logic save;
    logic restore;
    logic clear;
  } cell_ctl_t;

  function automatic logic signed [HID_W-1:0] rts_tanh(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] r;
    t = '0;
    r = '0;
    if (x >= 32'sd32767) begin
      r = 32'sd32767;
    end else if (x <= -32'sd32767) begin
      r = -32'sd32767;
    end else if (x >= 32'sd0) begin
      if (x < 32'sd8192) begin
        r = x;
      end else begin
        t = (x - 32'sd8192) * 32'sd3;
        r = 32'sd8192 + (t >>> 2);
      end
    end else begin
      if (x > -32'sd8192) begin
        r = x;
      end else begin
        t = (x + 32'sd8192) * 32'sd3;
        r = -32'sd8192 + (t >>> 2);
      end
    end
    return r[HID_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rts_if.sv
// valid/ready channel interfaces for items, results and configuration
// depends on rts_pkg
`default_nettype none

interface rts_in_if;
  import rts_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic signed [WEIGHT_W-1:0] weight;
  logic [TOKEN_W-1:0]  token;
  modport source (output valid, kind, row, col, weight, token, input ready);
  modport sink (input valid, kind, row, col, weight, token, output ready);
endinterface

interface rts_out_if;
  import rts_pkg::*;
  logic                valid;
  logic                ready;
  logic [PRED_W-1:0]   predicted;
  logic [CONF_W-1:0]   confidence;
  logic [MARGIN_W-1:0] margin;
  modport source (output valid, predicted, confidence, margin, input ready);
  modport sink (input valid, predicted, confidence, margin, output ready);
endinterface

interface rts_cfg_if;
  import rts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rts_cell.sv
// one hidden unit cell: live, saved and next value, linked to its neighbor
// depends on rts_pkg
`default_nettype none

module rts_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  rts_pkg::cell_ctl_t         ctl_i,
  input  wire signed [15:0]          h_i,
  input  wire signed [15:0]          nx_i,
  output logic signed [15:0]         h_o,
  output logic signed [15:0]         nx_o
);
  import rts_pkg::*;

  logic signed [HID_W-1:0] h_q;
  logic signed [HID_W-1:0] sv_q;
  logic signed [HID_W-1:0] nx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= '0;
      sv_q <= '0;
    end else if (ctl_i.clear) begin
      h_q  <= '0;
      sv_q <= '0;
    end else begin
      if (ctl_i.save) begin
        sv_q <= h_q;
      end
      if (ctl_i.restore) begin
        h_q <= sv_q;
      end else if (ctl_i.commit) begin
        h_q <= nx_q;
      end else if (ctl_i.rot) begin
        h_q <= h_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.nx_shift) begin
      nx_q <= nx_i;
    end
  end

  assign h_o  = h_q;
  assign nx_o = nx_q;

endmodule

`default_nettype wire

FILE: hdl/rts_datapath.sv
// weight memories and the shared multiply-accumulate pipeline
// depends on rts_pkg
`default_nettype none

module rts_datapath #(
  parameter int unsigned HIDDEN_UNITS  = 32,
  parameter int unsigned VOCAB_ENTRIES = 64,
  localparam int unsigned HB = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1,
  localparam int unsigned VB = $clog2(VOCAB_ENTRIES)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  rts_pkg::kind_e           wr_kind_i,
  input  wire                      wr_en_i,
  input  wire [VB+HB-1:0]          wr_vaddr_i,
  input  wire [HB+HB-1:0]          wr_raddr_i,
  input  wire signed [15:0]        wr_weight_i,
  input  rts_pkg::op_t             op_i,
  input  wire [VB+HB-1:0]          win_addr_i,
  input  wire [HB+HB-1:0]          rec_addr_i,
  input  wire [VB+HB-1:0]          out_addr_i,
  input  wire signed [15:0]        opnd_i,
  input  wire [4:0]                round_shift_i,
  input  wire [4:0]                product_shift_i,
  output logic                     logit_valid_o,
  output logic signed [31:0]       logit_o,
  output logic                     push_o,
  output logic signed [15:0]       push_val_o
);
  import rts_pkg::*;

  localparam int unsigned VDEPTH = VOCAB_ENTRIES * (2 ** HB);
  localparam int unsigned RDEPTH = HIDDEN_UNITS * (2 ** HB);

  logic [7:0]  win_mem [VDEPTH];
  logic [7:0]  rec_mem [RDEPTH];
  logic [15:0] out_mem [VDEPTH];

  logic [7:0]  win_rd_q;
  logic [7:0]  rec_rd_q;
  logic [15:0] out_rd_q;
  op_t         s1_q, s2_q, fin_q;
  logic signed [HID_W-1:0] opnd1_q;
  logic signed [ACC_W-1:0] prod_q, acc_q, fin_acc_q, r_q;
  logic        r_vld_q;

  logic signed [15:0]      a_w;
  logic signed [ACC_W-1:0] prod_d, term_w, acc_d, rnd_w, r_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (wr_kind_i)
        KIND_LOAD_IN:  win_mem[wr_vaddr_i] <= wr_weight_i[7:0];
        KIND_LOAD_REC: rec_mem[wr_raddr_i] <= wr_weight_i[7:0];
        KIND_LOAD_OUT: out_mem[wr_vaddr_i] <= wr_weight_i;
        default: ;
      endcase
    end
    win_rd_q <= win_mem[win_addr_i];
    rec_rd_q <= rec_mem[rec_addr_i];
    out_rd_q <= out_mem[out_addr_i];
  end

  always_comb begin
    if (s1_q.pred) begin
      a_w = out_rd_q;
    end else if (s1_q.first) begin
      a_w = {{8{win_rd_q[7]}}, win_rd_q};
    end else begin
      a_w = {{8{rec_rd_q[7]}}, rec_rd_q};
    end
    prod_d = a_w * opnd1_q;
    term_w = s2_q.pred ? (prod_q >>> product_shift_i) : prod_q;
    acc_d  = s2_q.first ? term_w : acc_q + term_w;
    rnd_w  = (round_shift_i == 5'd0) ? '0 : (32'sd1 <<< (round_shift_i - 5'd1));
    r_d    = (fin_acc_q + rnd_w) >>> round_shift_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      fin_q   <= '0;
      r_vld_q <= 1'b0;
    end else begin
      s1_q    <= op_i;
      s2_q    <= s1_q;
      fin_q   <= s2_q.valid && s2_q.last ? s2_q : '0;
      r_vld_q <= fin_q.valid && !fin_q.pred;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd1_q <= opnd_i;
    prod_q  <= prod_d;
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
    fin_acc_q <= acc_d;
    r_q       <= r_d;
  end

  assign logit_valid_o = fin_q.valid && fin_q.pred;
  assign logit_o       = fin_acc_q;
  assign push_o        = r_vld_q;
  assign push_val_o    = rts_tanh(r_q);

endmodule

`default_nettype wire

FILE: hdl/rnn_token_step_and_argmax_core.sv
// Fixed-point Elman cell with built-in weight memories. The hidden vector
// lives in a ring of HIDDEN_UNITS cells that rotates past one shared
// multiply-accumulate, one product per cycle. Token steps and predicts are
// both paced by that single MAC; loads, save, restore and clear are done
// as the item is accepted. One item is in work at a time; a finished result
// waits in the output register while the next item is taken. Predict
// answers with one transaction.
// depends on rts_pkg, rts_if, rts_cell, rts_datapath
`default_nettype none

module rnn_token_step_and_argmax_core #(
  parameter int unsigned HIDDEN_UNITS  = 32,
  parameter int unsigned VOCAB_ENTRIES = 64
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  rts_cfg_if.sink   cfg_i,
  rts_in_if.sink    in_i,
  rts_out_if.source out_o
);
  import rts_pkg::*;

  localparam int unsigned HB   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int unsigned VB   = $clog2(VOCAB_ENTRIES);
  localparam int unsigned NMAX = (VOCAB_ENTRIES > HIDDEN_UNITS) ? VOCAB_ENTRIES : HIDDEN_UNITS;
  localparam int unsigned OW   = $clog2(NMAX);
  localparam int unsigned IW   = $clog2(HIDDEN_UNITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_PRED, ST_DRAIN, ST_COMMIT, ST_CONF, ST_EMIT
  } state_e;

  state_e state_q;
  logic [OW-1:0] oc_q;
  logic [IW-1:0] ic_q;
  logic [2:0]    dc_q;
  logic [VB-1:0] token_q;
  logic [VB-1:0] lc_q;
  logic [VB-1:0] bidx_q;
  logic signed [ACC_W-1:0] best_q, second_q;
  logic          sv_q;
  logic [MARGIN_W-1:0] rem_q, margin_q;
  logic [CONF_W-1:0]   cf_q;
  logic signed [15:0]  scale_q;
  logic [4:0]    rs_q, ps_q;
  logic [15:0]   div_q;
  logic          out_valid_q;
  logic [PRED_W-1:0]   out_pred_q;
  logic [CONF_W-1:0]   out_conf_q;
  logic [MARGIN_W-1:0] out_margin_q;

  logic          in_acc, wr_en, in_range, op_last;
  kind_e         kind_w;
  op_t           op_w;
  cell_ctl_t     ctl_w;
  logic signed [15:0] opnd_w;
  logic [VB+HB-1:0] win_addr, out_addr;
  logic [HB+HB-1:0] rec_addr;
  logic [IW-1:0] ic_m1;
  logic          logit_valid, push;
  logic signed [ACC_W-1:0] logit;
  logic signed [15:0] push_val;
  logic signed [ACC_W:0] diff_w;
  logic [MARGIN_W-1:0] margin_w;
  logic [15:0]   div_w;

  logic signed [15:0] h_w  [HIDDEN_UNITS];
  logic signed [15:0] nx_w [HIDDEN_UNITS];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign kind_w      = kind_e'(in_i.kind);

  always_comb begin
    if (kind_w == KIND_LOAD_REC) begin
      in_range = (32'(in_i.row) < HIDDEN_UNITS) && (32'(in_i.col) < HIDDEN_UNITS);
    end else begin
      in_range = (32'(in_i.row) < VOCAB_ENTRIES) && (32'(in_i.col) < HIDDEN_UNITS);
    end
    wr_en = in_acc && in_range &&
            (kind_w == KIND_LOAD_IN || kind_w == KIND_LOAD_REC || kind_w == KIND_LOAD_OUT);
  end

  always_comb begin
    ic_m1        = ic_q - IW'(1);
    op_w.valid   = (state_q == ST_STEP) || (state_q == ST_PRED);
    op_w.pred    = (state_q == ST_PRED);
    op_w.first   = (ic_q == '0);
    op_last      = (state_q == ST_STEP) ? (32'(ic_q) == HIDDEN_UNITS)
                                        : (32'(ic_q) == HIDDEN_UNITS - 1);
    op_w.last    = op_last;
    opnd_w       = ((state_q == ST_STEP) && (ic_q == '0)) ? scale_q : h_w[0];
    win_addr     = {token_q, oc_q[HB-1:0]};
    rec_addr     = {ic_m1[HB-1:0], oc_q[HB-1:0]};
    out_addr     = {oc_q[VB-1:0], ic_q[HB-1:0]};
    ctl_w.rot      = op_w.valid && !((state_q == ST_STEP) && (ic_q == '0));
    ctl_w.nx_shift = push;
    ctl_w.commit   = (state_q == ST_COMMIT);
    ctl_w.save     = in_acc && (kind_w == KIND_SAVE);
    ctl_w.restore  = in_acc && (kind_w == KIND_RESTORE);
    ctl_w.clear    = in_acc && (kind_w == KIND_CLEAR);
  end

  rts_datapath #(
    .HIDDEN_UNITS  (HIDDEN_UNITS),
    .VOCAB_ENTRIES (VOCAB_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_kind_i       (kind_w),
    .wr_en_i         (wr_en),
    .wr_vaddr_i      ({in_i.row[VB-1:0], in_i.col[HB-1:0]}),
    .wr_raddr_i      ({in_i.row[HB-1:0], in_i.col[HB-1:0]}),
    .wr_weight_i     (in_i.weight),
    .op_i            (op_w),
    .win_addr_i      (win_addr),
    .rec_addr_i      (rec_addr),
    .out_addr_i      (out_addr),
    .opnd_i          (opnd_w),
    .round_shift_i   (rs_q),
    .product_shift_i (ps_q),
    .logit_valid_o   (logit_valid),
    .logit_o         (logit),
    .push_o          (push),
    .push_val_o      (push_val)
  );

  for (genvar k = 0; k < HIDDEN_UNITS; k++) begin : g_cell
    rts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w),
      .h_i    (h_w[(k + 1) % HIDDEN_UNITS]),
      .nx_i   ((k == HIDDEN_UNITS - 1) ? push_val : nx_w[(k + 1) % HIDDEN_UNITS]),
      .h_o    (h_w[k]),
      .nx_o   (nx_w[k])
    );
  end

  always_comb begin
    diff_w = {best_q[ACC_W-1], best_q} - {second_q[ACC_W-1], second_q};
    if (!sv_q || diff_w[ACC_W]) begin
      margin_w = '0;
    end else if (diff_w[ACC_W-1]) begin
      margin_w = '1;
    end else begin
      margin_w = diff_w[MARGIN_W-1:0];
    end
    div_w = (div_q == '0) ? 16'd1 : div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 16'sd1;
      rs_q    <= 5'd15;
      ps_q    <= 5'd8;
      div_q   <= 16'd1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_INPUT_SCALE:   scale_q <= cfg_i.data;
        CFG_ROUND_SHIFT:   rs_q    <= cfg_i.data[4:0];
        CFG_PRODUCT_SHIFT: ps_q    <= cfg_i.data[4:0];
        CFG_CONF_DIVISOR:  div_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      oc_q         <= '0;
      ic_q         <= '0;
      dc_q         <= '0;
      lc_q         <= '0;
      token_q      <= '0;
      bidx_q       <= '0;
      best_q       <= '0;
      second_q     <= '0;
      sv_q         <= 1'b0;
      rem_q        <= '0;
      margin_q     <= '0;
      cf_q         <= '0;
      out_valid_q  <= 1'b0;
      out_pred_q   <= '0;
      out_conf_q   <= '0;
      out_margin_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      if (logit_valid) begin
        lc_q <= lc_q + VB'(1);
        if (lc_q == '0) begin
          best_q <= logit;
          bidx_q <= '0;
        end else if (logit > best_q) begin
          second_q <= best_q;
          sv_q     <= 1'b1;
          best_q   <= logit;
          bidx_q   <= lc_q;
        end else if (!sv_q || logit > second_q) begin
          second_q <= logit;
          sv_q     <= 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          oc_q <= '0;
          ic_q <= '0;
          dc_q <= '0;
          if (in_acc && kind_w == KIND_STEP) begin
            token_q <= (32'(in_i.token) < VOCAB_ENTRIES) ? in_i.token[VB-1:0] : '0;
            state_q <= ST_STEP;
          end else if (in_acc && kind_w == KIND_PREDICT) begin
            lc_q    <= '0;
            sv_q    <= 1'b0;
            state_q <= ST_PRED;
          end
        end
        ST_STEP, ST_PRED: begin
          if (op_last) begin
            ic_q <= '0;
            if (((state_q == ST_STEP) && (32'(oc_q) == HIDDEN_UNITS - 1)) ||
                ((state_q == ST_PRED) && (32'(oc_q) == VOCAB_ENTRIES - 1))) begin
              state_q <= ST_DRAIN;
              cf_q    <= (state_q == ST_PRED) ? CONF_MAX : '0;
            end else begin
              oc_q <= oc_q + OW'(1);
            end
          end else begin
            ic_q <= ic_q + IW'(1);
          end
        end
        ST_DRAIN: begin
          dc_q <= dc_q + 3'd1;
          if (32'(dc_q) == DRAIN_CYCLES - 1) begin
            if (cf_q == CONF_MAX) begin
              margin_q <= margin_w;
              rem_q    <= margin_w;
              cf_q     <= '0;
              state_q  <= ST_CONF;
            end else begin
              state_q <= ST_COMMIT;
            end
          end
        end
        ST_COMMIT: begin
          state_q <= ST_IDLE;
        end
        ST_CONF: begin
          if (cf_q < CONF_MAX && rem_q >= MARGIN_W'(div_w)) begin
            rem_q <= rem_q - MARGIN_W'(div_w);
            cf_q  <= cf_q + 4'd1;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_pred_q   <= PRED_W'(bidx_q);
            out_conf_q   <= cf_q;
            out_margin_q <= margin_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.predicted  = out_pred_q;
  assign out_o.confidence = out_conf_q;
  assign out_o.margin     = out_margin_q;

endmodule

`default_nettype wire

FILE: hdl/rts_checker.sv
// port-level checks on the result channel of the rnn core, bound to the top
// depends on rnn_token_step_and_argmax_core_defines.svh
`include "rnn_token_step_and_argmax_core_defines.svh"
`default_nettype none

module rts_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid,
  input wire        out_ready,
  input wire [3:0]  confidence,
  input wire [30:0] margin
);

  `RTS_ASSERT(a_conf_max, clk_i, rst_ni, out_valid |-> (confidence <= 4'd8))
  `RTS_ASSERT(a_conf_zero, clk_i, rst_ni, (out_valid && margin == 31'd0) |-> (confidence == 4'd0))
  `RTS_ASSERT_HOLD(a_margin_hold, clk_i, rst_ni, out_valid, out_ready, margin)

endmodule

bind rnn_token_step_and_argmax_core rts_checker u_rts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .confidence (out_o.confidence),
  .margin     (out_o.margin)
);

`default_nettype wire

FILE: tb/rts_cell_monitor.sv
`timescale 1ns / 100ps
// predicting monitor for the rnn token step and argmax core: follows every
// config, item and result transaction and compares each result field by field
// depends on rts_pkg and rts_if
`default_nettype none

module rts_cell_monitor (
  input  wire clk_i,
  input  wire rst_ni,
  rts_cfg_if  cfg_m,
  rts_in_if   in_m,
  rts_out_if  out_m,
  output int  fail_count_o,
  output int  pending_o
);
  import rts_pkg::*;

  localparam int NH = 32;
  localparam int NV = 64;

  typedef struct {
    logic [PRED_W-1:0]   predicted;
    logic [CONF_W-1:0]   confidence;
    logic [MARGIN_W-1:0] margin;
  } argmax_t;

  argmax_t expected_argmax[$];
  int fails;

  logic signed [HID_W-1:0] hid[NH];
  logic signed [HID_W-1:0] hid_saved[NH];
  logic [7:0]  w_in[NV*NH];
  logic [7:0]  w_rec[NH*NH];
  logic [15:0] w_out[NV*NH];
  logic [15:0] scale_q;
  logic [4:0]  rshift_q;
  logic [4:0]  pshift_q;
  logic [15:0] divisor_q;

  assign fail_count_o = fails;

  function automatic logic signed [HID_W-1:0] squash(input logic signed [31:0] x);
    logic signed [31:0] r;
    if (x >= 32'sd32767) r = 32'sd32767;
    else if (x <= -32'sd32767) r = -32'sd32767;
    else if (x >= 32'sd0) r = (x < 32'sd8192) ? x : 32'sd8192 + (((x - 32'sd8192) * 32'sd3) >>> 2);
    else r = (x > -32'sd8192) ? x : -32'sd8192 + (((x + 32'sd8192) * 32'sd3) >>> 2);
    return r[HID_W-1:0];
  endfunction

  task automatic advance_hidden(input logic [7:0] tok);
    logic signed [HID_W-1:0] nxt[NH];
    logic signed [31:0] acc;
    logic signed [31:0] sc;
    int t;
    sc = {{16{scale_q[15]}}, scale_q};
    t = (tok < NV) ? int'(tok) : 0;
    for (int i = 0; i < NH; i++) begin
      acc = $signed({{24{w_in[t*NH+i][7]}}, w_in[t*NH+i]}) * sc;
      for (int j = 0; j < NH; j++) begin
        acc = acc + $signed({{24{w_rec[j*NH+i][7]}}, w_rec[j*NH+i]})
                  * $signed({{16{hid[j][15]}}, hid[j]});
      end
      if (rshift_q != 0) acc = acc + (32'sd1 <<< (rshift_q - 1));
      nxt[i] = squash(acc >>> rshift_q);
    end
    for (int i = 0; i < NH; i++) hid[i] = nxt[i];
  endtask

  function automatic argmax_t rank_logits();
    argmax_t r;
    logic [31:0] sum;
    logic signed [31:0] p;
    logic signed [31:0] p_sh;
    logic signed [31:0] best;
    logic signed [31:0] second;
    logic second_ok;
    longint d;
    longint dv;
    longint conf;
    best = 0;
    second = 0;
    second_ok = 1'b0;
    r.predicted = '0;
    d = 0;
    for (int v = 0; v < NV; v++) begin
      sum = '0;
      for (int j = 0; j < NH; j++) begin
        p = $signed({{16{w_out[v*NH+j][15]}}, w_out[v*NH+j]})
          * $signed({{16{hid[j][15]}}, hid[j]});
        p_sh = p >>> pshift_q;
        sum = sum + p_sh;
      end
      if (v == 0) begin
        best = $signed(sum);
      end else if ($signed(sum) > best) begin
        second = best;
        second_ok = 1'b1;
        best = $signed(sum);
        r.predicted = v[PRED_W-1:0];
      end else if (!second_ok || $signed(sum) > second) begin
        second = $signed(sum);
        second_ok = 1'b1;
      end
    end
    if (second_ok) begin
      d = longint'(best) - longint'(second);
      if (d < 0) d = 0;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
    end
    dv = (divisor_q == 0) ? 1 : longint'(divisor_q);
    conf = d / dv;
    if (conf > 8) conf = 8;
    r.confidence = conf[CONF_W-1:0];
    r.margin = d[MARGIN_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    argmax_t got;
    argmax_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NH; i++) begin
        hid[i] = '0;
        hid_saved[i] = '0;
      end
      scale_q = 16'd1;
      rshift_q = 5'd15;
      pshift_q = 5'd8;
      divisor_q = 16'd1;
      fails = 0;
      expected_argmax.delete();
      pending_o = 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          CFG_INPUT_SCALE:   scale_q = cfg_m.data;
          CFG_ROUND_SHIFT:   rshift_q = cfg_m.data[4:0];
          CFG_PRODUCT_SHIFT: pshift_q = cfg_m.data[4:0];
          CFG_CONF_DIVISOR:  divisor_q = cfg_m.data;
          default: ;
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        got.predicted = out_m.predicted;
        got.confidence = out_m.confidence;
        got.margin = out_m.margin;
        if (expected_argmax.size() == 0) begin
          $error("unexpected result transaction predicted %0d", got.predicted);
          fails++;
        end else begin
          want = expected_argmax.pop_front();
          if (got.predicted !== want.predicted) begin
            $error("predicted expected %0d actual %0d", want.predicted, got.predicted);
            fails++;
          end
          if (got.confidence !== want.confidence) begin
            $error("confidence expected %0d actual %0d", want.confidence, got.confidence);
            fails++;
          end
          if (got.margin !== want.margin) begin
            $error("margin expected %0d actual %0d", want.margin, got.margin);
            fails++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        case (kind_e'(in_m.kind))
          KIND_LOAD_IN:
            if (in_m.row < NV && in_m.col < NH) w_in[in_m.row*NH+in_m.col] = in_m.weight[7:0];
          KIND_LOAD_REC:
            if (in_m.row < NH && in_m.col < NH) w_rec[in_m.row*NH+in_m.col] = in_m.weight[7:0];
          KIND_LOAD_OUT:
            if (in_m.row < NV && in_m.col < NH) w_out[in_m.row*NH+in_m.col] = in_m.weight;
          KIND_STEP:    advance_hidden(in_m.token);
          KIND_PREDICT: expected_argmax.push_back(rank_logits());
          KIND_SAVE:    for (int i = 0; i < NH; i++) hid_saved[i] = hid[i];
          KIND_RESTORE: for (int i = 0; i < NH; i++) hid[i] = hid_saved[i];
          default: begin
            for (int i = 0; i < NH; i++) begin
              hid[i] = '0;
              hid_saved[i] = '0;
            end
          end
        endcase
      end
      pending_o = expected_argmax.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/rnn_token_step_and_argmax_core_test.sv
`timescale 1ns / 100ps
// top of the rnn token step and argmax core test: clock, reset, item and
// config stimulus under several idling phases, and the verdict
// depends on rts_pkg, rts_if, rts_cell_monitor and the core
`default_nettype none

module rnn_token_step_and_argmax_core_test;
  import rts_pkg::*;

  localparam int NH = 32;
  localparam int NV = 64;
  localparam int SETTLE_CYCLES = 2200;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_mode;

  rts_cfg_if cfg_bus();
  rts_in_if  in_bus();
  rts_out_if out_bus();

  rnn_token_step_and_argmax_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus.sink),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  rts_cell_monitor monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_m       (cfg_bus),
    .in_m        (in_bus),
    .out_m       (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_mode >= 2) out_bus.ready = ($urandom_range(99) >= (idle_mode == 2 ? 45 : 14));
      else out_bus.ready = 1'b1;
    end
  end

  task automatic send_item(input kind_e k, input logic [7:0] r, input logic [5:0] c,
                           input logic [15:0] w, input logic [7:0] t);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 45 : (idle_mode == 3 ? 14 : 0);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.kind = k;
    in_bus.row = r;
    in_bus.col = c;
    in_bus.weight = w;
    in_bus.token = t;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic release_item();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] d);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = d;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [7:0] r;
    pick = $urandom_range(99);
    r = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NV - 1));
    if (pick < 45)
      send_item(kind_e'($urandom_range(2)), r, 6'($urandom), 16'($urandom), 8'($urandom));
    else if (pick < 68)
      send_item(KIND_STEP, 8'($urandom), 6'($urandom), 16'($urandom),
                ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(NV - 1)));
    else if (pick < 84)
      send_item(KIND_PREDICT, 8'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
    else if (pick < 91)
      send_item(KIND_SAVE, 8'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
    else if (pick < 98)
      send_item(KIND_RESTORE, 8'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
    else
      send_item(KIND_CLEAR, 8'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [15:0] sc;
    idle_mode = 0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_SAVE;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.weight = '0;
    in_bus.token = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_INPUT_SCALE;
    cfg_bus.data = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill every weight memory before any step or predict reads it
    for (int r = 0; r < NV; r++)
      for (int c = 0; c < NH; c++)
        send_item(KIND_LOAD_IN, 8'(r), 6'(c), 16'($urandom), 8'($urandom));
    for (int r = 0; r < NH; r++)
      for (int c = 0; c < NH; c++)
        send_item(KIND_LOAD_REC, 8'(r), 6'(c), 16'($urandom), 8'($urandom));
    for (int r = 0; r < NV; r++)
      for (int c = 0; c < NH; c++)
        send_item(KIND_LOAD_OUT, 8'(r), 6'(c), 16'($urandom), 8'($urandom));

    // directed
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_LOAD_IN, 8'd0, 6'd0, 16'h7fff, 8'd0);
    send_item(KIND_LOAD_REC, 8'd31, 6'd31, 16'h8000, 8'd0);
    send_item(KIND_LOAD_OUT, 8'd63, 6'd31, 16'h8000, 8'd0);
    send_item(KIND_LOAD_OUT, 8'd0, 6'd0, 16'h7fff, 8'd0);
    send_item(KIND_LOAD_IN, 8'd64, 6'd0, 16'h1234, 8'd0);
    send_item(KIND_LOAD_REC, 8'd32, 6'd5, 16'hffff, 8'd0);
    send_item(KIND_LOAD_OUT, 8'd255, 6'd63, 16'hffff, 8'd0);
    send_item(KIND_LOAD_IN, 8'd3, 6'd32, 16'h00aa, 8'd0);
    send_item(KIND_STEP, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_STEP, 8'd0, 6'd0, 16'd0, 8'd63);
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_SAVE, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_STEP, 8'd0, 6'd0, 16'd0, 8'd64);
    send_item(KIND_STEP, 8'hff, 6'h3f, 16'hffff, 8'd255);
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_RESTORE, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_CLEAR, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_RESTORE, 8'd0, 6'd0, 16'd0, 8'd0);
    send_item(KIND_STEP, 8'd0, 6'd0, 16'd0, 8'd1);
    send_item(KIND_PREDICT, 8'd0, 6'd0, 16'd0, 8'd0);
    release_item();

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      sc = 16'($urandom);
      case (ph)
        1: begin
          write_reg(CFG_INPUT_SCALE, 16'h7fff);
          write_reg(CFG_ROUND_SHIFT, {11'($urandom), 5'd24});
          write_reg(CFG_PRODUCT_SHIFT, {11'($urandom), 5'd16});
          write_reg(CFG_CONF_DIVISOR, 16'hffff);
        end
        2: begin
          write_reg(CFG_INPUT_SCALE, 16'h8000);
          write_reg(CFG_ROUND_SHIFT, {11'($urandom), 5'd1});
          write_reg(CFG_PRODUCT_SHIFT, {11'($urandom), 5'd0});
          write_reg(CFG_CONF_DIVISOR, 16'd1);
        end
        3: begin
          write_reg(CFG_INPUT_SCALE, sc);
          write_reg(CFG_ROUND_SHIFT, {11'($urandom), 5'd0});
          write_reg(CFG_PRODUCT_SHIFT, {11'($urandom), 5'd31});
          write_reg(CFG_CONF_DIVISOR, 16'd0);
        end
        4: begin
          write_reg(CFG_INPUT_SCALE, sc);
          write_reg(CFG_ROUND_SHIFT, {11'($urandom), 5'($urandom_range(24, 1))});
          write_reg(CFG_PRODUCT_SHIFT, {11'($urandom), 5'($urandom_range(16))});
          write_reg(CFG_CONF_DIVISOR, 16'($urandom_range(1000, 1)));
        end
        5: begin
          write_reg(CFG_INPUT_SCALE, 16'd1);
          write_reg(CFG_ROUND_SHIFT, {11'($urandom), 5'd15});
          write_reg(CFG_PRODUCT_SHIFT, {11'($urandom), 5'd8});
          write_reg(CFG_CONF_DIVISOR, 16'd3);
        end
        default: ;
      endcase
      idle_mode = ph % 4;
      for (int n = 0; n < 47; n++) random_item();
      release_item();
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
